/* rtl/beqe_pkg.sv */
// Shared types and constants for the block error quality estimator.
`default_nettype none
package beqe_pkg;

	localparam logic ACT_SAMPLE = 1'b0;
	localparam logic ACT_EMIT   = 1'b1;

	localparam logic [15:0] RATE_ONE  = 16'd32768;
	localparam logic [7:0]  QMAX      = 8'd255;
	localparam logic [7:0]  DEPTH_RST = 8'd4;

	typedef struct packed {
		logic        action;
		logic        in_range;
		logic [9:0]  blk;
		logic [15:0] rate;
		logic [15:0] span;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} fe_out_t;

	typedef struct packed {
		logic take;
		logic clearing;
	} be_stat_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_SUM,
		ST_PREP,
		ST_DIV,
		ST_OUT
	} be_state_t;

endpackage
`default_nettype wire

/* rtl/beqe_front.sv */
// Front end: accepts items, classifies them and queues them for the back end.
`default_nettype none
module beqe_front #(
	parameter int MAX_BLOCKS = 1024
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push,
	output logic             full,
	input  wire              action,
	input  wire [9:0]        block_index,
	input  wire [15:0]       error_rate,
	input  wire [15:0]       span_count,
	input  beqe_pkg::be_stat_t stat,
	output beqe_pkg::fe_out_t  fe_out
);
	import beqe_pkg::*;

	item_t       slot_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	logic        accept;
	item_t       cls;

	assign full   = (count_q == 2'd2) || stat.clearing;
	assign accept = push && !full;

	always_comb begin
		cls.action   = action;
		cls.in_range = ({7'd0, block_index} < 17'(MAX_BLOCKS));
		cls.blk      = block_index;
		cls.rate     = (error_rate > RATE_ONE) ? RATE_ONE : error_rate;
		cls.span     = span_count;
	end

	always_ff @(posedge clk) begin
		if (accept)
			slot_q[wr_ptr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (accept)
				wr_ptr_q <= ~wr_ptr_q;
			if (stat.take)
				rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, accept} - {1'b0, stat.take};
		end
	end

	assign fe_out.valid = (count_q != 2'd0);
	assign fe_out.item  = slot_q[rd_ptr_q];

endmodule
`default_nettype wire

/* rtl/beqe_back.sv */
// Back end: per-block count and kept-rate memories, insertion, sum and divide.
`default_nettype none
module beqe_back #(
	parameter int MAX_BLOCKS = 1024,
	parameter int MAX_KEEP   = 16
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire [7:0]         coverage_depth,
	input  beqe_pkg::fe_out_t fe_out,
	output beqe_pkg::be_stat_t stat,
	output logic              empty,
	input  wire               pop,
	output logic [9:0]        block_out,
	output logic [7:0]        quality
);
	import beqe_pkg::*;

	localparam int BLK_AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int LW     = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
	localparam int KW     = $clog2(MAX_KEEP + 1);
	localparam int SW     = 16 + KW;
	localparam int NW     = SW + 9;
	localparam int RW     = MAX_KEEP * 16;

	logic [7:0]        cnt_mem [MAX_BLOCKS];
	logic [RW-1:0]     row_mem [MAX_BLOCKS];

	be_state_t         state_q, state_d;
	item_t             cur_q;
	logic [BLK_AW-1:0] clr_q;
	logic [7:0]        cnt_rd_q;
	logic [RW-1:0]     row_rd_q;
	logic [KW-1:0]     idx_q;
	logic [SW-1:0]     acc_q;
	logic [NW-1:0]     rem_q;
	logic [NW-1:0]     dsh_q;
	logic [2:0]        step_q;
	logic [7:0]        qual_q;
	logic              out_valid_q;
	logic [9:0]        out_blk_q;
	logic [7:0]        out_qual_q;

	logic              take;
	logic              rd_en;
	logic [BLK_AW-1:0] rd_addr;
	logic [BLK_AW-1:0] cur_addr;
	logic              cnt_we;
	logic [BLK_AW-1:0] cnt_wa;
	logic [7:0]        cnt_wd;
	logic              row_we;
	logic [RW-1:0]     row_new;
	logic [MAX_KEEP-1:0] le;
	logic [6:0]        d4;
	logic [KW-1:0]     k;
	logic              supported;
	logic              out_load;
	logic [NW:0]       trial;

	// Keep amount: d/4, at least one, at most MAX_KEEP.
	always_comb begin
		d4 = {1'b0, coverage_depth[7:2]};
		if (d4 == 7'd0)
			k = KW'(1);
		else if (d4 > 7'(MAX_KEEP))
			k = KW'(MAX_KEEP);
		else
			k = KW'(d4);
	end

	assign rd_addr  = BLK_AW'(fe_out.item.blk);
	assign cur_addr = BLK_AW'(cur_q.blk);
	assign take     = (state_q == ST_IDLE) && fe_out.valid;
	assign rd_en    = take && fe_out.item.in_range;
	assign out_load = !out_valid_q || pop;
	assign supported = ({8'd0, cnt_rd_q} >= 16'(k)) && (cur_q.span >= 16'(k));
	assign trial    = {1'b0, rem_q} - {1'b0, dsh_q};

	assign stat.take     = take;
	assign stat.clearing = (state_q == ST_CLEAR);

	// Ordered insert: lanes at or below the new rate hold, the first lane above takes it,
	// later lanes shift up by one.
	always_comb begin
		for (int i = 0; i < MAX_KEEP; i++)
			le[i] = (cnt_rd_q > 8'(i)) && (row_rd_q[i*16 +: 16] <= cur_q.rate);
		for (int i = 0; i < MAX_KEEP; i++) begin
			if (le[i])
				row_new[i*16 +: 16] = row_rd_q[i*16 +: 16];
			else if (i == 0)
				row_new[i*16 +: 16] = cur_q.rate;
			else if (le[(i > 0) ? i - 1 : 0])
				row_new[i*16 +: 16] = cur_q.rate;
			else
				row_new[i*16 +: 16] = row_rd_q[((i > 0) ? i - 1 : 0)*16 +: 16];
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_we  = 1'b0;
		cnt_wa  = cur_addr;
		cnt_wd  = 8'd0;
		row_we  = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cnt_we = 1'b1;
				cnt_wa = clr_q;
				if (clr_q == BLK_AW'(MAX_BLOCKS - 1))
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (take) begin
					if (fe_out.item.in_range)
						state_d = ST_EXEC;
					else if (fe_out.item.action == ACT_EMIT)
						state_d = ST_OUT;
				end
			end
			ST_EXEC: begin
				cnt_we = 1'b1;
				if (cur_q.action == ACT_SAMPLE) begin
					cnt_wd  = (cnt_rd_q == QMAX) ? QMAX : cnt_rd_q + 8'd1;
					row_we  = 1'b1;
					state_d = ST_IDLE;
				end else begin
					state_d = supported ? ST_SUM : ST_OUT;
				end
			end
			ST_SUM: begin
				if (idx_q == k - KW'(1))
					state_d = ST_PREP;
			end
			ST_PREP: state_d = ST_DIV;
			ST_DIV: begin
				if (step_q == 3'd0)
					state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_load)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cnt_we)
			cnt_mem[cnt_wa] <= cnt_wd;
		if (rd_en)
			cnt_rd_q <= cnt_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (row_we)
			row_mem[cur_addr] <= row_new;
		if (rd_en)
			row_rd_q <= row_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR)
				clr_q <= clr_q + BLK_AW'(1);
			if (state_q == ST_OUT && out_load)
				out_valid_q <= 1'b1;
			else if (pop)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (take) begin
					cur_q  <= fe_out.item;
					qual_q <= QMAX;
				end
			end
			ST_EXEC: begin
				idx_q <= '0;
				acc_q <= '0;
			end
			ST_SUM: begin
				acc_q <= acc_q + SW'(row_rd_q[idx_q[LW-1:0]*16 +: 16]);
				idx_q <= idx_q + KW'(1);
			end
			ST_PREP: begin
				// numerator 255*S + k*16384, divisor k*32768 aligned to the top quotient bit
				rem_q  <= NW'({acc_q, 8'd0}) - NW'(acc_q) + (NW'(k) << 14);
				dsh_q  <= NW'(k) << 22;
				step_q <= 3'd7;
				qual_q <= 8'd0;
			end
			ST_DIV: begin
				if (!trial[NW])
					rem_q <= trial[NW-1:0];
				qual_q <= {qual_q[6:0], !trial[NW]};
				dsh_q  <= dsh_q >> 1;
				step_q <= step_q - 3'd1;
			end
			ST_OUT: begin
				if (out_load) begin
					out_blk_q  <= cur_q.blk;
					out_qual_q <= qual_q;
				end
			end
			default: ;
		endcase
	end

	assign empty     = !out_valid_q;
	assign block_out = out_blk_q;
	assign quality   = out_qual_q;

`ifndef SYNTHESIS
	a_no_take_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !take)
		else $error("item taken during clearing pass");
	a_sample_two_cycles: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC && cur_q.action == ACT_SAMPLE) |=> (state_q == ST_IDLE))
		else $error("sample did not retire after update");
	a_sum_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SUM) |-> (idx_q < k))
		else $error("sum index past keep amount");
	a_div_after_prep: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PREP) |=> (state_q == ST_DIV && step_q == 3'd7))
		else $error("divider not started");
`endif

endmodule
`default_nettype wire

/* rtl/block_error_quality_estimator.sv */
// Top level: configuration register, front end and back end.
//  channel  | handshake          | payload
//  input    | push / full        | action, block_index, error_rate, span_count
//  result   | empty / pop        | block_out, quality
//  config   | cfg_we             | cfg_wdata (coverage depth)
// A sample in the back end reads the count and row memories, then writes both back.
// A supported emit: read, check, sum of k kept rates, prep, 8 divider steps, output.
// Undersupported emits skip the divide; out of range, emits go to output, samples drop.
// After reset a clearing pass zeroes the counts of MAX_BLOCKS blocks; full stays high.
// A two-entry queue parts front and back; a one-entry result register parts back and pop.
`default_nettype none
module block_error_quality_estimator #(
	parameter int MAX_BLOCKS = 1024,
	parameter int MAX_KEEP   = 16
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        cfg_we,
	input  wire [7:0]  cfg_wdata,
	input  wire        push,
	output logic       full,
	input  wire        action,
	input  wire [9:0]  block_index,
	input  wire [15:0] error_rate,
	input  wire [15:0] span_count,
	output logic       empty,
	input  wire        pop,
	output logic [9:0] block_out,
	output logic [7:0] quality
);
	import beqe_pkg::*;

	logic [7:0] coverage_depth_q;
	fe_out_t    fe_out;
	be_stat_t   stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			coverage_depth_q <= DEPTH_RST;
		else if (cfg_we)
			coverage_depth_q <= cfg_wdata;
	end

	beqe_front #(
		.MAX_BLOCKS(MAX_BLOCKS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.action     (action),
		.block_index(block_index),
		.error_rate (error_rate),
		.span_count (span_count),
		.stat       (stat),
		.fe_out     (fe_out)
	);

	beqe_back #(
		.MAX_BLOCKS(MAX_BLOCKS),
		.MAX_KEEP  (MAX_KEEP)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.coverage_depth(coverage_depth_q),
		.fe_out        (fe_out),
		.stat          (stat),
		.empty         (empty),
		.pop           (pop),
		.block_out     (block_out),
		.quality       (quality)
	);

endmodule
`default_nettype wire
